// File: rtl/core/kat_pkg.sv
// Package for the key autorepeat tracker: sequencer states, register
// indexes, field widths and the packed table entry type.
// Used by key_autorepeat_tracker and its testbench; depends on nothing.
package kat_pkg;

    // Field widths of the event and the table entry.
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL  = 8'd1;

    // Register reset values in milliseconds.
    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd300;
    localparam logic [DELAY_W-1:0] REPEAT_IVL_RST  = 16'd100;

    // Press count limits.
    localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // Event kinds.
    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // One held-key entry as stored in the table memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_time;
        logic [CNT_W-1:0]  press_count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

endpackage

// File: rtl/core/kat_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Used by key_autorepeat_tracker for the held-key table; no dependencies.
module kat_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable; the read data is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/key_autorepeat_tracker.sv
// Key autorepeat tracker. An accepted item walks the whole table through the single memory
// port, one entry read per cycle, and checks each entry as its registered read data returns;
// the update step then updates the table and loads the output register, waiting on out_stall.
// A new item is accepted only in idle, after the previous item's result has been registered.
// Reset: asynchronous, active low; clears all entry valid bits and loads the
// delay registers with 300 ms and 100 ms. Table memory contents are not reset.
module key_autorepeat_tracker #(
    parameter int HELD_KEYS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Event input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [kat_pkg::KEY_W-1:0]          key_code,
    input  logic [kat_pkg::TIME_W-1:0]         event_time,
    // Action output channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               act_valid,
    output logic [kat_pkg::KEY_W-1:0]          act_key,
    output logic                               act_repeat,
    output logic                               table_full_drop,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kat_pkg::DELAY_W-1:0]        cfg_data
);

    localparam int AW = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HELD_KEYS - 1);

    // Configuration registers.
    logic [kat_pkg::DELAY_W-1:0] first_delay_reg;
    logic [kat_pkg::DELAY_W-1:0] repeat_ivl_reg;

    // Sequencer and latched item.
    kat_pkg::state_t             state_reg, state_next;
    logic                        mode_reg, mode_next;
    logic [kat_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [kat_pkg::TIME_W-1:0]  time_reg, time_next;

    // Table walk.
    logic [AW-1:0]               scan_addr_reg, scan_addr_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        found_reg, found_next;
    logic [AW-1:0]               hit_idx_reg, hit_idx_next;
    logic [kat_pkg::TIME_W-1:0]  hit_time_reg, hit_time_next;
    logic [kat_pkg::CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic                        free_found_reg, free_found_next;
    logic [AW-1:0]               free_idx_reg, free_idx_next;
    logic [HELD_KEYS-1:0]        valid_reg, valid_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic                        act_valid_reg, act_valid_next;
    logic [kat_pkg::KEY_W-1:0]   act_key_reg, act_key_next;
    logic                        act_repeat_reg, act_repeat_next;
    logic                        drop_reg, drop_next;

    // Memory port.
    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    kat_pkg::entry_t             ram_wdata;
    kat_pkg::entry_t             ram_rdata;

    // Update-step arithmetic.
    logic [kat_pkg::DELAY_W-1:0] delay;
    logic [kat_pkg::TIME_W-1:0]  elapsed;
    logic                        due;
    logic                        out_free;
    logic                        in_accept;

    kat_ram #(
        .WIDTH (kat_pkg::ENTRY_W),
        .DEPTH (HELD_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_stall        = (state_reg != kat_pkg::ST_IDLE);
    assign in_accept       = in_valid && !in_stall;
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign act_valid       = act_valid_reg;
    assign act_key         = act_key_reg;
    assign act_repeat      = act_repeat_reg;
    assign table_full_drop = drop_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Repeat due test: wrapped elapsed time against the current delay.
    assign delay   = (hit_cnt_reg == kat_pkg::CNT_ONE) ? first_delay_reg : repeat_ivl_reg;
    assign elapsed = time_reg - hit_time_reg;
    assign due     = (elapsed >= {{(kat_pkg::TIME_W - kat_pkg::DELAY_W){1'b0}}, delay});

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg <= kat_pkg::FIRST_DELAY_RST;
            repeat_ivl_reg  <= kat_pkg::REPEAT_IVL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == kat_pkg::CFG_FIRST_DELAY)
            begin
                first_delay_reg <= cfg_data;
            end
            else if (cfg_index == kat_pkg::CFG_REPEAT_IVL)
            begin
                repeat_ivl_reg <= cfg_data;
            end
        end
    end

    // Next state, table walk and update step.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_time_next   = hit_time_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        act_valid_next  = act_valid_reg;
        act_key_next    = act_key_reg;
        act_repeat_next = act_repeat_reg;
        drop_next       = drop_reg;
        ram_we          = 1'b0;
        ram_addr        = scan_addr_reg;
        ram_wdata       = '{key: key_reg, last_time: time_reg, press_count: kat_pkg::CNT_ONE};

        unique case (state_reg)
            kat_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next       = mode;
                    key_next        = key_code;
                    time_next       = event_time;
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = kat_pkg::ST_SCAN;
                end
            end

            kat_pkg::ST_SCAN:
            begin
                // Issue one read per cycle until every entry has been asked for.
                if (!issue_done_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_addr_reg;
                    if (scan_addr_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + AW'(1);
                    end
                end

                // Check the entry read last cycle; keep the lowest hit and free slot.
                if (rd_pend_reg)
                begin
                    if (valid_reg[rd_idx_reg])
                    begin
                        if (!found_reg && ram_rdata.key == key_reg)
                        begin
                            found_next    = 1'b1;
                            hit_idx_next  = rd_idx_reg;
                            hit_time_next = ram_rdata.last_time;
                            hit_cnt_next  = ram_rdata.press_count;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = kat_pkg::ST_EXEC;
                    end
                end
            end

            kat_pkg::ST_EXEC:
            begin
                ram_addr = found_reg ? hit_idx_reg : free_idx_reg;
                if (out_free)
                begin
                    state_next      = kat_pkg::ST_IDLE;
                    out_valid_next  = 1'b1;
                    act_valid_next  = 1'b0;
                    act_key_next    = '0;
                    act_repeat_next = 1'b0;
                    drop_next       = 1'b0;
                    if (mode_reg == kat_pkg::MODE_PRESS)
                    begin
                        if (found_reg)
                        begin
                            // Held key: repeat once the delay has passed.
                            if (due)
                            begin
                                ram_we                = 1'b1;
                                ram_wdata.press_count = (hit_cnt_reg == kat_pkg::CNT_MAX)
                                                        ? hit_cnt_reg
                                                        : hit_cnt_reg + kat_pkg::CNT_ONE;
                                act_valid_next        = 1'b1;
                                act_key_next          = key_reg;
                                act_repeat_next       = 1'b1;
                            end
                        end
                        else if (free_found_reg)
                        begin
                            // New key takes the lowest free slot.
                            ram_we                  = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            act_valid_next          = 1'b1;
                            act_key_next            = key_reg;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (found_reg)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = kat_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kat_pkg::ST_IDLE;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        time_reg       <= time_next;
        scan_addr_reg  <= scan_addr_next;
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_time_reg   <= hit_time_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_idx_reg   <= free_idx_next;
        act_valid_reg  <= act_valid_next;
        act_key_reg    <= act_key_next;
        act_repeat_reg <= act_repeat_next;
        drop_reg       <= drop_next;
    end

`ifndef SYNTH
    // An accepted item always starts a table walk.
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == kat_pkg::ST_SCAN))
        else $error("accepted item did not start a table walk");

    // Table writes happen only in the update step, and leave the entry valid.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == kat_pkg::ST_EXEC) && out_free)
        else $error("table written outside the update step");

    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_addr)])
        else $error("written entry is not marked valid");

    // A dropped press never carries an action, and a repeat is always an action.
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(act_valid && table_full_drop) && (act_valid || !act_repeat))
        else $error("inconsistent result flags");

    // A hit found during the walk must point at a valid entry.
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kat_pkg::ST_EXEC) && found_reg |-> valid_reg[hit_idx_reg])
        else $error("hit entry is not valid");
`endif

endmodule

// File: test/kat_checker.sv
// Checker for the key autorepeat tracker: watches the event, action and register channels,
// predicts each action item from its own copy of the held-key table and compares in order.
// Depends on kat_pkg for field widths, register indexes, event kinds and the entry type.
module kat_checker #(
    parameter int HELD_KEYS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          mode,
    input  logic [kat_pkg::KEY_W-1:0]     key_code,
    input  logic [kat_pkg::TIME_W-1:0]    event_time,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          act_valid,
    input  logic [kat_pkg::KEY_W-1:0]     act_key,
    input  logic                          act_repeat,
    input  logic                          table_full_drop,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kat_pkg::DELAY_W-1:0]   cfg_data,
    output int unsigned                   mismatches,
    output int unsigned                   outstanding
);

    // One predicted action item.
    typedef struct packed {
        logic                      fired;
        logic [kat_pkg::KEY_W-1:0] key;
        logic                      repeated;
        logic                      dropped;
    } action_t;

    // Shadow copy of the held-key table and the delay registers.
    logic                        held [HELD_KEYS];
    kat_pkg::entry_t             held_table [HELD_KEYS];
    logic [kat_pkg::DELAY_W-1:0] first_delay;
    logic [kat_pkg::DELAY_W-1:0] repeat_ivl;

    action_t     pending_actions [$];
    int unsigned error_count = 0;

    // Apply one key event to the shadow table and return the action it causes.
    function automatic action_t predict_action(logic ev_mode,
                                               logic [kat_pkg::KEY_W-1:0] ev_key,
                                               logic [kat_pkg::TIME_W-1:0] now);
        action_t                     act;
        int                          hit;
        int                          free_slot;
        int                          i;
        logic [kat_pkg::DELAY_W-1:0] due;
        logic [kat_pkg::TIME_W-1:0]  elapsed;
        act       = '0;
        hit       = -1;
        free_slot = -1;
        // Walk downward so that the lowest matching and lowest free slots win.
        for (i = HELD_KEYS - 1; i >= 0; i--)
        begin
            if (held[i] && held_table[i].key == ev_key)
                hit = i;
            if (!held[i])
                free_slot = i;
        end
        if (ev_mode == kat_pkg::MODE_RELEASE)
        begin
            if (hit >= 0)
                held[hit] = 1'b0;
        end
        else if (hit >= 0)
        begin
            // The first repeat waits the first delay; later ones the interval.
            due     = (held_table[hit].press_count == kat_pkg::CNT_ONE)
                      ? first_delay : repeat_ivl;
            elapsed = now - held_table[hit].last_time;
            if (elapsed >= {{(kat_pkg::TIME_W - kat_pkg::DELAY_W){1'b0}}, due})
            begin
                held_table[hit].last_time = now;
                if (held_table[hit].press_count != kat_pkg::CNT_MAX)
                    held_table[hit].press_count = held_table[hit].press_count
                                                  + kat_pkg::CNT_ONE;
                act.fired    = 1'b1;
                act.key      = ev_key;
                act.repeated = 1'b1;
            end
        end
        else if (free_slot >= 0)
        begin
            held[free_slot]                   = 1'b1;
            held_table[free_slot].key         = ev_key;
            held_table[free_slot].last_time   = now;
            held_table[free_slot].press_count = kat_pkg::CNT_ONE;
            act.fired = 1'b1;
            act.key   = ev_key;
        end
        else
        begin
            act.dropped = 1'b1;
        end
        return act;
    endfunction

    task automatic check_key(string name, logic [kat_pkg::KEY_W-1:0] want,
                             logic [kat_pkg::KEY_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_flag(string name, logic want, logic got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
        end
    endtask

    // Track register writes, predict on accepted events, compare accepted actions.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        action_t want;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < HELD_KEYS; i++)
                held[i] = 1'b0;
            first_delay = kat_pkg::FIRST_DELAY_RST;
            repeat_ivl  = kat_pkg::REPEAT_IVL_RST;
            pending_actions.delete();
            outstanding <= 0;
            mismatches  <= error_count;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == kat_pkg::CFG_FIRST_DELAY)
                    first_delay = cfg_data;
                else if (cfg_index == kat_pkg::CFG_REPEAT_IVL)
                    repeat_ivl = cfg_data;
            end
            // New predictions go to the tail of the queue.
            if (in_valid && !in_stall)
                pending_actions.insert(pending_actions.size(),
                                       predict_action(mode, key_code, event_time));
            if (out_valid && !out_stall)
            begin
                if (pending_actions.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected action item, expected none, actual %b %h %b %b",
                             $time, act_valid, act_key, act_repeat, table_full_drop);
                end
                else
                begin
                    want = pending_actions.pop_front();
                    check_flag("act_valid", want.fired, act_valid);
                    check_key("act_key", want.key, act_key);
                    check_flag("act_repeat", want.repeated, act_repeat);
                    check_flag("table_full_drop", want.dropped, table_full_drop);
                end
            end
            outstanding <= pending_actions.size();
            mismatches  <= error_count;
        end
    end

endmodule

// File: test/tb_key_autorepeat_tracker.sv
// Testbench top for the key autorepeat tracker: clock, reset, key event and register
// stimulus, random stalls on the action channel, and the final verdict.
// Depends on kat_pkg, key_autorepeat_tracker and kat_checker.
module tb_key_autorepeat_tracker;

    localparam int HELD_KEYS    = 8;
    localparam int POOL_KEYS    = 12;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 45;
    localparam int BURST_KEY    = 10;
    localparam int BURST_LEN    = 260;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // Register index that maps to no register.
    localparam logic [kat_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          mode       = kat_pkg::MODE_PRESS;
    logic [kat_pkg::KEY_W-1:0]     key_code   = '0;
    logic [kat_pkg::TIME_W-1:0]    event_time = '0;
    logic                          out_stall  = 1'b0;
    logic                          cfg_valid  = 1'b0;
    logic [kat_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [kat_pkg::DELAY_W-1:0]   cfg_data   = '0;
    logic                          in_stall;
    logic                          out_valid;
    logic                          act_valid;
    logic [kat_pkg::KEY_W-1:0]     act_key;
    logic                          act_repeat;
    logic                          table_full_drop;
    logic                          cfg_ready;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;

    int                          idle_pct  = 0;
    int                          stall_pct = 0;
    logic [kat_pkg::DELAY_W-1:0] cur_first = kat_pkg::FIRST_DELAY_RST;
    logic [kat_pkg::DELAY_W-1:0] cur_ivl   = kat_pkg::REPEAT_IVL_RST;
    logic [kat_pkg::KEY_W-1:0]   key_pool [POOL_KEYS];
    logic [kat_pkg::TIME_W-1:0]  clock_ms;

    key_autorepeat_tracker #(
        .HELD_KEYS(HELD_KEYS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .key_code       (key_code),
        .event_time     (event_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .act_valid      (act_valid),
        .act_key        (act_key),
        .act_repeat     (act_repeat),
        .table_full_drop(table_full_drop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    kat_checker #(
        .HELD_KEYS(HELD_KEYS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .key_code       (key_code),
        .event_time     (event_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .act_valid      (act_valid),
        .act_key        (act_key),
        .act_repeat     (act_repeat),
        .table_full_drop(table_full_drop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Random stalls on the action channel.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one key event, after an optional idle gap, and wait until it is taken.
    task automatic send_event(logic ev_mode, logic [kat_pkg::KEY_W-1:0] ev_key,
                              logic [kat_pkg::TIME_W-1:0] ev_time);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= ev_mode;
        key_code   <= ev_key;
        event_time <= ev_time;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering events and wait until every predicted action has come back.
    task automatic drain_actions();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_delay_reg(logic [kat_pkg::CFG_IDX_W-1:0] idx,
                                   logic [kat_pkg::DELAY_W-1:0] value);
        drain_actions();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Time step between presses of a held key, clustered around the delay thresholds.
    function automatic logic [kat_pkg::TIME_W-1:0] typematic_gap();
        case ($urandom_range(5))
            0: return $urandom_range(0, 3);
            1: return {{(kat_pkg::TIME_W - kat_pkg::DELAY_W){1'b0}}, cur_first} - 1
                      + $urandom_range(0, 2);
            2: return {{(kat_pkg::TIME_W - kat_pkg::DELAY_W){1'b0}}, cur_ivl} - 1
                      + $urandom_range(0, 2);
            3: return $urandom_range(0, 2 * cur_first + 10);
            4: return $urandom_range(0, 70000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly held-key sequences with random timing; the rest is loose events and noise.
    task automatic random_traffic(inout int count);
        int                         r;
        int                         n;
        int                         i;
        logic [kat_pkg::KEY_W-1:0]  k;
        logic [kat_pkg::TIME_W-1:0] t;
        r = $urandom_range(99);
        k = key_pool[$urandom_range(POOL_KEYS - 1)];
        if (r < 70)
        begin
            t = clock_ms;
            send_event(kat_pkg::MODE_PRESS, k, t);
            count++;
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
            begin
                t = t + typematic_gap();
                send_event(kat_pkg::MODE_PRESS, k, t);
                count++;
            end
            // Some keys are left held so that the table fills up.
            if ($urandom_range(3) != 0)
            begin
                send_event(kat_pkg::MODE_RELEASE, k, t);
                count++;
            end
            clock_ms = t + $urandom_range(0, 50);
        end
        else if (r < 85)
        begin
            send_event(kat_pkg::MODE_RELEASE, k, clock_ms);
            count++;
        end
        else if (r < 95)
        begin
            send_event(kat_pkg::MODE_PRESS, $urandom(), clock_ms);
            count++;
        end
        else
        begin
            clock_ms = $urandom();
            send_event($urandom_range(1) ? kat_pkg::MODE_RELEASE : kat_pkg::MODE_PRESS,
                       k, clock_ms);
            count++;
        end
    endtask

    initial
    begin : stimulus
        int                         ph;
        int                         i;
        int                         sent;
        logic                       paused;
        logic [kat_pkg::TIME_W-1:0] t;
        logic [31:0]                rnd;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom();
        clock_ms = $urandom();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first delay and interval boundaries across the time wrap.
        t = 32'hFFFF_FF00;
        send_event(kat_pkg::MODE_PRESS, key_pool[0], t);
        send_event(kat_pkg::MODE_PRESS, key_pool[0], t + 299);
        send_event(kat_pkg::MODE_PRESS, key_pool[0], t + 300);
        send_event(kat_pkg::MODE_PRESS, key_pool[0], t + 399);
        send_event(kat_pkg::MODE_PRESS, key_pool[0], t + 400);
        send_event(kat_pkg::MODE_RELEASE, key_pool[0], t + 410);
        // A release of a key that is not held does nothing.
        send_event(kat_pkg::MODE_RELEASE, key_pool[0], t + 420);
        // Fill the table, then a new key is dropped.
        for (i = 1; i <= HELD_KEYS; i++)
            send_event(kat_pkg::MODE_PRESS, key_pool[i], (i <= 4) ? 32'hFFFF_FFFF : 32'h0);
        send_event(kat_pkg::MODE_PRESS, key_pool[9], 32'h0);
        // A freed slot is reused by the next new key.
        send_event(kat_pkg::MODE_RELEASE, key_pool[3], 32'h10);
        send_event(kat_pkg::MODE_PRESS, key_pool[9], 32'h20);
        send_event(kat_pkg::MODE_PRESS, key_pool[1], 32'd299);
        for (i = 1; i <= 9; i++)
            send_event(kat_pkg::MODE_RELEASE, key_pool[i], 32'd400);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 59; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 59; end
                default: begin idle_pct = 19; stall_pct <= 19; end
            endcase
            case (ph)
                1: begin cur_first = 16'd0;    cur_ivl = 16'd0;    end
                2: begin cur_first = 16'hFFFF; cur_ivl = 16'd3;    end
                3: begin cur_first = 16'hFFFF; cur_ivl = 16'hFFFF; end
                4: begin cur_first = 16'd1;    cur_ivl = 16'd1;    end
                5:
                begin
                    rnd       = $urandom();
                    cur_first = rnd[kat_pkg::DELAY_W-1:0];
                    rnd       = $urandom_range(0, 2000);
                    cur_ivl   = rnd[kat_pkg::DELAY_W-1:0];
                end
                6: begin cur_first = 16'd0;    cur_ivl = 16'hFFFF; end
                7: begin cur_first = 16'hFFFF; cur_ivl = 16'd0;    end
                default:
                begin
                    cur_first = kat_pkg::FIRST_DELAY_RST;
                    cur_ivl   = kat_pkg::REPEAT_IVL_RST;
                end
            endcase
            // The first phase runs on the reset values; an unmapped index must be ignored.
            if (ph == 0)
            begin
                rnd = $urandom();
                write_delay_reg(CFG_UNUSED, rnd[kat_pkg::DELAY_W-1:0]);
            end
            else
            begin
                write_delay_reg(kat_pkg::CFG_FIRST_DELAY, cur_first);
                write_delay_reg(kat_pkg::CFG_REPEAT_IVL, cur_ivl);
            end

            // A saturated press count keeps using the short interval.
            if (ph == 2)
            begin
                t = clock_ms + 3;
                send_event(kat_pkg::MODE_PRESS, key_pool[BURST_KEY], t);
                send_event(kat_pkg::MODE_PRESS, key_pool[BURST_KEY], t + 3);
                clock_ms = t + 3;
            end

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    drain_actions();
                    paused = 1'b1;
                end
                random_traffic(sent);
            end

            // With zero delays every press repeats: drive the press count into saturation.
            if (ph == 1)
            begin
                for (i = 0; i < POOL_KEYS; i++)
                    send_event(kat_pkg::MODE_RELEASE, key_pool[i], clock_ms);
                for (i = 0; i < BURST_LEN; i++)
                    send_event(kat_pkg::MODE_PRESS, key_pool[BURST_KEY], clock_ms);
            end
        end

        drain_actions();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: key_autorepeat_tracker.f
rtl/core/kat_pkg.sv
rtl/core/kat_ram.sv
rtl/core/key_autorepeat_tracker.sv
test/kat_checker.sv
test/tb_key_autorepeat_tracker.sv
